@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the steering core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

@@ rtl/core/wfs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Steering package
// Types, constants and the arctangent table of the steering core.
// ----------------------------------------------------------------------------
package wfs_pkg;

   localparam int CordicStagesDefault = 16;
   localparam int MaxStages = 24;
   // CORDIC datapath width: Q16 mm values with growth headroom.
   localparam int CordicWidth = 36;
   // Angle accumulator width, Q24 radians.
   localparam int AngleWidth = 27;
   localparam int DistWidth = 16;

   localparam logic [15:0] Cos45Q16 = 16'd46341;
   localparam logic [15:0] InvGainQ16 = 16'd39796;
   localparam logic signed [16:0] GoalRadius = 17'sd1000;
   localparam logic [16:0] OutwardMargin = 17'd600;
   localparam logic signed [11:0] QuarterTurn = 12'sd1571;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth = 16;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_WALL_GAP        = 3'd0,
      CSR_CORNER_LIMIT    = 3'd1,
      CSR_FORWARD_SPEED   = 3'd2,
      CSR_MAX_TURN_RATE   = 3'd3,
      CSR_FOLLOW_LEFT     = 3'd4,
      CSR_GAIN_DISTANCE   = 3'd5,
      CSR_GAIN_ANGLE      = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_FOLLOW  = 2'd0,
      ACT_INWARD  = 2'd1,
      ACT_OUTWARD = 2'd2,
      ACT_STOP    = 2'd3
   } action_type;

   typedef struct packed {
      logic [15:0] wall_gap;
      logic [15:0] corner_limit;
      logic [10:0] forward_speed;
      logic [11:0] max_turn_rate;
      logic        follow_left;
      logic [11:0] gain_distance;
      logic [11:0] gain_angle;
   } csr_type;

   // Decision and side data carried alongside the CORDIC cells.
   typedef struct packed {
      action_type         action;
      logic signed [11:0] turn_angle;
      logic [10:0]        linear_speed;
   } tag_type;

   function automatic logic signed [AngleWidth-1:0] atan_q24(input int idx);
      logic signed [AngleWidth-1:0] r;
      case (idx)
         0: r = 27'sd13176795;  1: r = 27'sd7778716;  2: r = 27'sd4110060;
         3: r = 27'sd2086331;   4: r = 27'sd1047214;  5: r = 27'sd524117;
         6: r = 27'sd262123;    7: r = 27'sd131069;   8: r = 27'sd65536;
         9: r = 27'sd32768;    10: r = 27'sd16384;   11: r = 27'sd8192;
         12: r = 27'sd4096;    13: r = 27'sd2048;    14: r = 27'sd1024;
         15: r = 27'sd512;     16: r = 27'sd256;     17: r = 27'sd128;
         18: r = 27'sd64;      19: r = 27'sd32;      20: r = 27'sd16;
         21: r = 27'sd8;       22: r = 27'sd4;       23: r = 27'sd2;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/core/wfs_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface wfs_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/wall_follow_steering.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall-following steering controller
// Decides stop, corner turn, outward turn or proportional steering for each scan item.
// ----------------------------------------------------------------------------
// The block takes one scan item per clock and returns one command item per
// scan item, in order. An item flows through a fixed pipeline of
// 2*CORDIC_STAGES + 6 register stages: two input stages that form the Q16
// vectors, a chain of vectoring CORDIC cells that find the wall angle, a
// chain of rotation cells that project the lateral range onto the wall
// normal, then rounding, gain multiply, sum and saturation stages. The whole
// pipeline advances whenever its output register is empty or being taken,
// so the sustained rate is one item per cycle. The goal, corner and lost-wall
// decisions are made at entry and ride along the chain beside the CORDIC data.
// Configuration registers are written through the csr_ port and must only
// change while idle.
`include "assert_macros.svh"

module wall_follow_steering #(
   parameter int CORDIC_STAGES = wfs_pkg::CordicStagesDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [wfs_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [wfs_pkg::CsrDataWidth-1:0]      csr_write_data,
   wfs_stream_if.sink                            req_stream,
   wfs_stream_if.source                          rsp_stream
);
   localparam int Cw = wfs_pkg::CordicWidth;
   localparam int Aw = wfs_pkg::AngleWidth;
   // Stages: 2 entry, 2*N cells, 4 back end (round, multiply, sum, saturate).
   localparam int Depth = 2 * CORDIC_STAGES + 6;

   typedef struct packed {
      logic [15:0]        front_range;
      logic [15:0]        diagonal_distance;
      logic [15:0]        lateral_distance;
      logic signed [15:0] position_x;
      logic signed [15:0] position_y;
   } req_payload_type;

   // Configuration registers.
   wfs_pkg::csr_type csr_ff, csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (wfs_pkg::csr_index_type'(csr_index))
            wfs_pkg::CSR_WALL_GAP:      csr_in.wall_gap = csr_write_data;
            wfs_pkg::CSR_CORNER_LIMIT:  csr_in.corner_limit = csr_write_data;
            wfs_pkg::CSR_FORWARD_SPEED: csr_in.forward_speed = csr_write_data[10:0];
            wfs_pkg::CSR_MAX_TURN_RATE: csr_in.max_turn_rate = csr_write_data[11:0];
            wfs_pkg::CSR_FOLLOW_LEFT:   csr_in.follow_left = csr_write_data[0];
            wfs_pkg::CSR_GAIN_DISTANCE: csr_in.gain_distance = csr_write_data[11:0];
            wfs_pkg::CSR_GAIN_ANGLE:    csr_in.gain_angle = csr_write_data[11:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '{wall_gap: 16'd500, corner_limit: 16'd350,
                     forward_speed: 11'd300, max_turn_rate: 12'd500,
                     follow_left: 1'b0, gain_distance: 12'd256,
                     gain_angle: 12'd384};
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Pipeline flow control: the entire chain stalls only when the output
   // holds an item that the sink does not take. No item is taken in reset.
   logic [Depth-1:0] valid_ff;
   logic             advance;
   assign advance = !valid_ff[Depth-1] || rsp_stream.ready;
   assign req_stream.ready = advance && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[Depth-2:0], req_stream.valid};
      end
   end

   // Entry stage 0: decisions and operand capture.
   req_payload_type       rq;
   wfs_pkg::tag_type      tag_in;
   logic                  goal, corner, lost;
   logic signed [11:0]    side_turn;
   assign rq = req_stream.payload;

   always_comb begin
      goal = (17'(rq.position_x) >= -wfs_pkg::GoalRadius)
          && (17'(rq.position_x) <= wfs_pkg::GoalRadius)
          && (17'(rq.position_y) >= -wfs_pkg::GoalRadius)
          && (17'(rq.position_y) <= wfs_pkg::GoalRadius);
      corner = rq.front_range < csr_ff.corner_limit;
      lost = {1'b0, rq.lateral_distance}
           > ({1'b0, csr_ff.wall_gap} + wfs_pkg::OutwardMargin);
      side_turn = csr_ff.follow_left ? -wfs_pkg::QuarterTurn : wfs_pkg::QuarterTurn;
      tag_in = '0;
      if (goal) begin
         tag_in.action = wfs_pkg::ACT_STOP;
      end else if (corner) begin
         tag_in.action = wfs_pkg::ACT_INWARD;
         tag_in.turn_angle = -side_turn;
      end else if (lost) begin
         tag_in.action = wfs_pkg::ACT_OUTWARD;
         tag_in.turn_angle = side_turn;
      end else begin
         tag_in.action = wfs_pkg::ACT_FOLLOW;
         tag_in.linear_speed = csr_ff.forward_speed;
      end
   end

   // Tag rides along every stage up to the output register; the lateral
   // range rides along until the rotation chain starts.
   wfs_pkg::tag_type tag_ff [Depth-1];
   logic [15:0]      lat_ff [CORDIC_STAGES+2];

   always_ff @(posedge clock) begin
      if (advance) begin
         tag_ff[0] <= tag_in;
         lat_ff[0] <= rq.lateral_distance;
         for (int i = 1; i < Depth-1; i++) tag_ff[i] <= tag_ff[i-1];
         for (int i = 1; i < CORDIC_STAGES+2; i++) lat_ff[i] <= lat_ff[i-1];
      end
   end

   // Stage 0 products, stage 1 vector.
   logic [31:0] diag_prod_ff;
   logic        zero0_ff;
   logic signed [Cw-1:0] x0_ff, y0_ff;
   logic        zero1_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         diag_prod_ff <= rq.diagonal_distance * wfs_pkg::Cos45Q16;
         zero0_ff <= (rq.diagonal_distance == '0) && (rq.lateral_distance == '0);
         x0_ff <= Cw'(signed'({1'b0, diag_prod_ff}));
         y0_ff <= Cw'(signed'({1'b0, diag_prod_ff}))
                - Cw'(signed'({1'b0, lat_ff[0], 16'd0}));
         zero1_ff <= zero0_ff;
      end
   end

   // Vectoring chain.
   logic signed [Cw-1:0] vx [CORDIC_STAGES+1];
   logic signed [Cw-1:0] vy [CORDIC_STAGES+1];
   logic signed [Aw-1:0] vz [CORDIC_STAGES+1];
   logic                 vzero [CORDIC_STAGES+1];
   assign vx[0] = x0_ff;
   assign vy[0] = y0_ff;
   assign vz[0] = '0;
   assign vzero[0] = zero1_ff;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_vec
      wfs_vec_cell #(.Shift(g)) u_cell (
         .clock(clock), .enable(advance),
         .x_in(vx[g]), .y_in(vy[g]), .z_in(vz[g]), .zero_in(vzero[g]),
         .x_out(vx[g+1]), .y_out(vy[g+1]), .z_out(vz[g+1]),
         .zero_out(vzero[g+1]));
   end

   // Alpha is zero for a degenerate vector.
   logic signed [Aw-1:0] alpha;
   assign alpha = vzero[CORDIC_STAGES] ? '0 : vz[CORDIC_STAGES];

   // Rotation chain, started at (lat * inverse gain, 0). The multiply
   // sits in front of the first cell as combinational entry logic.
   logic signed [Cw-1:0] rx [CORDIC_STAGES+1];
   logic signed [Cw-1:0] ry [CORDIC_STAGES+1];
   logic signed [Aw-1:0] rz [CORDIC_STAGES+1];
   logic [31:0]          lat_gain;
   assign lat_gain = lat_ff[CORDIC_STAGES+1] * wfs_pkg::InvGainQ16;
   assign rx[0] = Cw'(signed'({1'b0, lat_gain}));
   assign ry[0] = '0;
   assign rz[0] = alpha;

   // Alpha is carried along the rotation chain for the angle term.
   logic signed [Aw-1:0] alpha_ff [CORDIC_STAGES];
   always_ff @(posedge clock) begin
      if (advance) begin
         alpha_ff[0] <= alpha;
         for (int i = 1; i < CORDIC_STAGES; i++) alpha_ff[i] <= alpha_ff[i-1];
      end
   end

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
      wfs_rot_cell #(.Shift(g)) u_cell (
         .clock(clock), .enable(advance),
         .x_in(rx[g]), .y_in(ry[g]), .z_in(rz[g]),
         .x_out(rx[g+1]), .y_out(ry[g+1]), .z_out(rz[g+1]));
   end

   // Back end stage A: rounding to mm and mrad.
   logic signed [Cw-1:0]  side_sum;
   logic signed [Aw+10:0] alpha_scaled;
   logic signed [19:0]    side_mm_ff;
   logic signed [12:0]    alpha_mrad_ff;
   assign side_sum = rx[CORDIC_STAGES] + Cw'(32768);
   assign alpha_scaled = (Aw+11)'(alpha_ff[CORDIC_STAGES-1]) * (Aw+11)'(1000)
                       + (Aw+11)'(1 << 23);

   always_ff @(posedge clock) begin
      if (advance) begin
         side_mm_ff <= 20'(side_sum >>> 16);
         alpha_mrad_ff <= 13'(alpha_scaled >>> 24);
      end
   end

   // Stage B: gain products.
   logic signed [20:0] err_d;
   logic signed [33:0] prod_d_ff, prod_a_ff;
   assign err_d = 21'(side_mm_ff) - 21'(signed'({1'b0, csr_ff.wall_gap}));

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_d_ff <= 34'(err_d) * 34'(signed'({1'b0, csr_ff.gain_distance}));
         prod_a_ff <= 34'(alpha_mrad_ff) * 34'(signed'({1'b0, csr_ff.gain_angle}));
      end
   end

   // Stage C: sum and round.
   logic signed [34:0] sum_rnd;
   logic signed [26:0] rate_raw_ff;
   assign sum_rnd = 35'(prod_d_ff) + 35'(prod_a_ff) + 35'sd128;

   always_ff @(posedge clock) begin
      if (advance) begin
         rate_raw_ff <= 27'(sum_rnd >>> 8);
      end
   end

   // Stage D: saturate and form the result.
   logic signed [26:0] lim;
   logic signed [12:0] rate_sat;
   wfs_pkg::tag_type   tag_out;
   assign lim = 27'(signed'({1'b0, csr_ff.max_turn_rate}));
   assign tag_out = tag_ff[Depth-2];

   always_comb begin
      if (rate_raw_ff > lim) rate_sat = 13'(lim);
      else if (rate_raw_ff < -lim) rate_sat = 13'(-lim);
      else rate_sat = 13'(rate_raw_ff);
      if (tag_out.action != wfs_pkg::ACT_FOLLOW) rate_sat = '0;
   end

   logic [1:0]         action_ff;
   logic [10:0]        speed_ff;
   logic signed [12:0] rate_ff;
   logic signed [11:0] turn_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         action_ff <= tag_out.action;
         speed_ff  <= tag_out.linear_speed;
         rate_ff   <= rate_sat;
         turn_ff   <= tag_out.turn_angle;
      end
   end

   assign rsp_stream.valid = valid_ff[Depth-1];
   assign rsp_stream.payload = {action_ff, speed_ff, rate_ff, turn_ff};

   `ASSERT_IMPL(a_follow_speed, clock, reset,
      rsp_stream.valid && action_ff != wfs_pkg::ACT_FOLLOW,
      speed_ff == '0 && rate_ff == '0, "non-follow item carries speed or rate")
   `ASSERT_IMPL(a_turn_only, clock, reset,
      rsp_stream.valid && (action_ff == wfs_pkg::ACT_FOLLOW || action_ff == wfs_pkg::ACT_STOP),
      turn_ff == '0, "turn angle outside a turn")
   `ASSERT_NEXT(a_stall_hold, clock, reset,
      rsp_stream.valid && !rsp_stream.ready,
      rsp_stream.valid && $stable(rsp_stream.payload),
      "output item changed while stalled")
endmodule

@@ rtl/core/wfs_vec_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vectoring cell
// One CORDIC vectoring micro-rotation with its pipeline register.
// ----------------------------------------------------------------------------
module wfs_vec_cell #(
   parameter int Shift = 0
) (
   input  logic                                    clock,
   input  logic                                    enable,
   input  logic signed [wfs_pkg::CordicWidth-1:0]  x_in,
   input  logic signed [wfs_pkg::CordicWidth-1:0]  y_in,
   input  logic signed [wfs_pkg::AngleWidth-1:0]   z_in,
   input  logic                                    zero_in,
   output logic signed [wfs_pkg::CordicWidth-1:0]  x_out,
   output logic signed [wfs_pkg::CordicWidth-1:0]  y_out,
   output logic signed [wfs_pkg::AngleWidth-1:0]   z_out,
   output logic                                    zero_out
);
   logic signed [wfs_pkg::CordicWidth-1:0] x_ff, y_ff, x_in_nx, y_in_nx;
   logic signed [wfs_pkg::AngleWidth-1:0]  z_ff, z_in_nx;
   logic                                   zero_ff;

   always_comb begin
      if (y_in >= 0) begin
         x_in_nx = x_in + (y_in >>> Shift);
         y_in_nx = y_in - (x_in >>> Shift);
         z_in_nx = z_in + wfs_pkg::atan_q24(Shift);
      end else begin
         x_in_nx = x_in - (y_in >>> Shift);
         y_in_nx = y_in + (x_in >>> Shift);
         z_in_nx = z_in - wfs_pkg::atan_q24(Shift);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff    <= x_in_nx;
         y_ff    <= y_in_nx;
         z_ff    <= z_in_nx;
         zero_ff <= zero_in;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
   assign zero_out = zero_ff;
endmodule

@@ rtl/core/wfs_rot_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation cell
// One CORDIC rotation micro-step with its pipeline register.
// ----------------------------------------------------------------------------
module wfs_rot_cell #(
   parameter int Shift = 0
) (
   input  logic                                    clock,
   input  logic                                    enable,
   input  logic signed [wfs_pkg::CordicWidth-1:0]  x_in,
   input  logic signed [wfs_pkg::CordicWidth-1:0]  y_in,
   input  logic signed [wfs_pkg::AngleWidth-1:0]   z_in,
   output logic signed [wfs_pkg::CordicWidth-1:0]  x_out,
   output logic signed [wfs_pkg::CordicWidth-1:0]  y_out,
   output logic signed [wfs_pkg::AngleWidth-1:0]   z_out
);
   logic signed [wfs_pkg::CordicWidth-1:0] x_ff, y_ff, x_in_nx, y_in_nx;
   logic signed [wfs_pkg::AngleWidth-1:0]  z_ff, z_in_nx;

   always_comb begin
      if (z_in >= 0) begin
         x_in_nx = x_in - (y_in >>> Shift);
         y_in_nx = y_in + (x_in >>> Shift);
         z_in_nx = z_in - wfs_pkg::atan_q24(Shift);
      end else begin
         x_in_nx = x_in + (y_in >>> Shift);
         y_in_nx = y_in - (x_in >>> Shift);
         z_in_nx = z_in + wfs_pkg::atan_q24(Shift);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in_nx;
         y_ff <= y_in_nx;
         z_ff <= z_in_nx;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
endmodule
